>>> sv/salc_pkg.sv
`default_nettype none
package salc_pkg;
   localparam int SETS_DEF = 256;
   localparam int WAYS_DEF = 8;
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_STORE  = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;
   localparam logic [1:0] CMD_BAD    = 2'd3;   // unknown command: no access
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic        first_hit;
      logic        evicted;
      logic [1:0]  hits_added;
      logic [31:0] total_hits;
      logic [31:0] total_misses;
      logic [31:0] total_evictions;
   } rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == COUNT_MAX) ? v : v + 32'd1;
   endfunction
endpackage
`default_nettype wire

>>> sv/salc_if.sv
`default_nettype none
interface salc_req_if;
   import salc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface salc_rsp_if;
   import salc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/set_assoc_lru_cache_tag_engine.sv
`default_nettype none
// Set-associative LRU tag engine. Each request beat (load, store or modify of
// a 64-bit address) gives one response beat with per-item hit/evict flags and
// saturating running totals. All ways of a set live in one wide synchronous
// memory row (valid, tag, stamp per way), read into a register and
// written back after the tag compare. An access has a read state and an
// update state; a load or store makes one access, a modify two (its second
// access rereads the row just written). After reset a clearing pass writes
// every row to zero; no request is taken during it. Set bits above
// log2(SETS) are clamped; ways_in_use of 0 acts as 1 and values above WAYS
// act as WAYS.
module set_assoc_lru_cache_tag_engine #(
   parameter int SETS = salc_pkg::SETS_DEF,
   parameter int WAYS = salc_pkg::WAYS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   salc_req_if.sink         req,
   salc_rsp_if.source       rsp,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);
   import salc_pkg::*;

   localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int MAXSB = $clog2(SETS + 1) - 1;
   localparam int WW  = $clog2(WAYS + 1);
   localparam int WI  = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef struct packed {
      logic        valid;
      logic [63:0] tag;
      logic [63:0] stamp;
   } line_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_UPD   = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   line_type mem [SETS][WAYS];
   line_type row_ff [WAYS];

   state_type   state_ff, state_in;
   logic [3:0]  set_bits_ff;
   logic [4:0]  block_bits_ff;
   logic [3:0]  ways_ff;
   logic [SW:0] clr_ff;
   logic [1:0]  cmd_ff;
   logic [63:0] addr_ff;
   logic        second_ff;
   logic [63:0] clock_ff;
   logic [31:0] hits_ff, misses_ff, evicts_ff;
   logic        first_hit_ff, evicted_ff;
   logic [1:0]  added_ff;

   // Address split under the current config.
   logic [3:0]    sb;
   logic [5:0]    shift;
   logic [63:0]   set_full;
   logic [SW-1:0] set_idx;
   logic [63:0]   tag;
   logic [WW-1:0] nw;

   always_comb begin
      sb = (set_bits_ff > 4'(MAXSB)) ? 4'(MAXSB) : set_bits_ff;
      shift = 6'(sb) + 6'(block_bits_ff);
      set_full = (addr_ff >> block_bits_ff) & ((64'd1 << sb) - 64'd1);
      set_idx = set_full[SW-1:0];
      tag = (shift > 6'd63) ? 64'd0 : (addr_ff >> shift);
      if (ways_ff == 4'd0) nw = WW'(1);
      else if (32'(ways_ff) > WAYS) nw = WW'(WAYS);
      else nw = WW'(ways_ff);
   end

   // Hit search and victim choice over the row read last cycle.
   logic          hit;
   logic [WI-1:0] hit_way, victim;
   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      victim = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (WW'(i) < nw && row_ff[i].valid && row_ff[i].tag == tag) begin
            hit = 1'b1;
            hit_way = WI'(i);
         end
      end
      for (int i = 1; i < WAYS; i++) begin
         if (WW'(i) < nw && row_ff[i].stamp < row_ff[victim].stamp)
            victim = WI'(i);
      end
   end

   logic [WI-1:0] sel_way;
   assign sel_way = hit ? hit_way : victim;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == (SW+1)'(SETS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req.valid) state_in = ST_READ;
         ST_READ:  state_in = ST_UPD;
         ST_UPD:   state_in = (cmd_ff == CMD_MODIFY && !second_ff) ? ST_READ : ST_RESP;
         ST_RESP:  if (rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_RESP);
   assign rsp.data  = '{first_hit: first_hit_ff, evicted: evicted_ff,
                        hits_added: added_ff, total_hits: hits_ff,
                        total_misses: misses_ff, total_evictions: evicts_ff};

   // Row memory: clear sweep, read, and write back of the chosen way.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         for (int i = 0; i < WAYS; i++) mem[clr_ff[SW-1:0]][i] <= '0;
      end else if (state_ff == ST_UPD && cmd_ff != CMD_BAD) begin
         mem[set_idx][sel_way] <= '{valid: 1'b1, tag: tag, stamp: clock_ff};
      end
      if (state_ff == ST_READ) begin
         for (int i = 0; i < WAYS; i++) row_ff[i] <= mem[set_idx][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         set_bits_ff <= 4'd4;
         block_bits_ff <= 5'd4;
         ways_ff <= 4'd8;
         clock_ff <= 64'd1;
         hits_ff <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
         second_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff <= csr_wdata[3:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
               CSR_WAYS:       ways_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req.valid) begin
            cmd_ff <= req.data.command;
            addr_ff <= req.data.address;
            second_ff <= 1'b0;
            first_hit_ff <= 1'b0;
            evicted_ff <= 1'b0;
            added_ff <= 2'd0;
         end
         // Unknown command: skip the update, leave totals alone.
         if (state_ff == ST_UPD && cmd_ff != CMD_BAD) begin
            clock_ff <= clock_ff + 64'd1;
            second_ff <= 1'b1;
            if (hit) begin
               hits_ff <= sat_inc(hits_ff);
               added_ff <= added_ff + 2'd1;
               if (!second_ff) first_hit_ff <= 1'b1;
            end else begin
               misses_ff <= sat_inc(misses_ff);
               if (row_ff[victim].valid) begin
                  evicts_ff <= sat_inc(evicts_ff);
                  if (!second_ff) evicted_ff <= 1'b1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import salc_pkg::*;

   localparam int SETS  = SETS_DEF;
   localparam int WAYS  = WAYS_DEF;
   localparam int LINES = SETS * WAYS;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [4:0] csr_wdata;

   salc_req_if req_ch ();
   salc_rsp_if rsp_ch ();

   set_assoc_lru_cache_tag_engine #(.SETS(SETS), .WAYS(WAYS)) DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   // Shadow of the tag store and the counters, kept beside the block.
   logic        shadow_valid [LINES];
   logic [63:0] shadow_tag   [LINES];
   logic [63:0] shadow_stamp [LINES];
   logic [63:0] shadow_clock;
   logic [31:0] shadow_hits, shadow_misses, shadow_evicts;
   logic [3:0]  cfg_set_bits;
   logic [4:0]  cfg_block_bits;
   logic [3:0]  cfg_ways;

   rsp_type expected_rsps[$];
   int mismatches;
   int cycle_count;
   idle_mode_type idle_mode;
   int hold_off;          // cycles the receiver still refuses beats

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] count_up(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // One access to the shadow store; return hit, flag a valid-line eviction.
   function automatic logic shadow_access(input logic [63:0] address,
                                          output logic evict);
      int sb, bb, nw, base, victim;
      logic [63:0] set_idx, tag;
      sb = (cfg_set_bits > $clog2(SETS)) ? $clog2(SETS) : cfg_set_bits;
      bb = cfg_block_bits;
      nw = (cfg_ways == 0) ? 1 : (cfg_ways > WAYS) ? WAYS : cfg_ways;
      set_idx = (address >> bb) & ((64'd1 << sb) - 64'd1);
      tag = (sb + bb >= 64) ? 64'd0 : address >> (sb + bb);
      base = int'(set_idx) * WAYS;
      victim = 0;
      evict = 1'b0;
      for (int i = 0; i < nw; i++) begin
         if (shadow_valid[base + i] && shadow_tag[base + i] == tag) begin
            shadow_stamp[base + i] = shadow_clock;
            shadow_clock++;
            shadow_hits = count_up(shadow_hits);
            return 1'b1;
         end
      end
      shadow_misses = count_up(shadow_misses);
      for (int i = 1; i < nw; i++)
         if (shadow_stamp[base + i] < shadow_stamp[base + victim]) victim = i;
      if (shadow_valid[base + victim]) begin
         shadow_evicts = count_up(shadow_evicts);
         evict = 1'b1;
      end
      shadow_valid[base + victim] = 1'b1;
      shadow_tag[base + victim] = tag;
      shadow_stamp[base + victim] = shadow_clock;
      shadow_clock++;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_access(input req_type r);
      rsp_type p;
      logic ev2;
      p = '0;
      if (r.command != CMD_BAD) begin
         p.first_hit = shadow_access(r.address, p.evicted);
         p.hits_added = {1'b0, p.first_hit};
         if (r.command == CMD_MODIFY && shadow_access(r.address, ev2))
            p.hits_added++;
      end
      p.total_hits = shadow_hits;
      p.total_misses = shadow_misses;
      p.total_evictions = shadow_evicts;
      return p;
   endfunction

   // Sample the response channel at the rising edge; compare with the oldest.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", rsp_ch.data);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response mismatch: hit %b/%b evict %b/%b added %0d/%0d",
                            " totals %0d %0d %0d / %0d %0d %0d"},
                     want.first_hit, rsp_ch.data.first_hit, want.evicted, rsp_ch.data.evicted,
                     want.hits_added, rsp_ch.data.hits_added, want.total_hits,
                     want.total_misses, want.total_evictions, rsp_ch.data.total_hits,
                     rsp_ch.data.total_misses, rsp_ch.data.total_evictions);
            end
         end
      end
   end

   // Receiver: stall by phase, or hold off entirely for a long stretch.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_mode == IDLE_SNK)
         rsp_ch.ready <= ($urandom_range(99) >= 60);
      else if (idle_mode == IDLE_BOTH)
         rsp_ch.ready <= ($urandom_range(99) >= 27);
      else
         rsp_ch.ready <= 1'b1;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Write one register between phases, and mirror it.
   task automatic write_csr(input logic [1:0] index, input logic [4:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_SET_BITS:   cfg_set_bits = value[3:0];
         CSR_BLOCK_BITS: cfg_block_bits = value;
         CSR_WAYS:       cfg_ways = value[3:0];
         default: ;
      endcase
   endtask

   // Offer one beat; hold it until accepted, then predict it. Valid drops
   // only on an idle cycle or at the end of a batch, so back-to-back beats
   // keep it high. A typed expectation overrides the predictor, which still
   // advances.
   task automatic send_item(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type p;
      if (idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) begin
         while ($urandom_range(99) < ((idle_mode == IDLE_SRC) ? 60 : 27)) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      p = predict_access(r);
      expected_rsps.push_back(typed ? typed_rsp : p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // Mostly addresses that reuse a small pool so sets fill, hit and evict.
   function automatic req_type random_item(input logic [63:0] pool[8]);
      req_type r;
      int pick;
      pick = $urandom_range(99);
      r.command = (pick < 3) ? CMD_BAD : 2'($urandom_range(2));
      if (pick < 80)
         r.address = pool[$urandom_range(7)] ^ 64'($urandom_range(15));
      else
         r.address = {$urandom, $urandom};
      return r;
   endfunction

   typedef struct {
      req_type    item;
      logic       typed;
      rsp_type    want;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      logic [63:0] pool[8];
      rsp_type z;
      req_type r;
      z = '0;
      mismatches = 0;
      cycle_count = 0;
      hold_off = 0;
      idle_mode = IDLE_NONE;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SET_BITS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      for (int i = 0; i < LINES; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_tag[i] = '0;
         shadow_stamp[i] = '0;
      end
      shadow_clock = 64'd1;
      shadow_hits = '0;
      shadow_misses = '0;
      shadow_evicts = '0;
      cfg_set_bits = 4'd4;
      cfg_block_bits = 5'd4;
      cfg_ways = 4'd8;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: typed rows are readable at a glance.
      rows.push_back('{'{CMD_BAD, 64'h0}, 1'b1, z});                   // unknown command first
      rows.push_back('{'{CMD_LOAD, 64'h0}, 1'b1, '{0, 0, 0, 0, 1, 0}}); // cold miss
      rows.push_back('{'{CMD_LOAD, 64'h8}, 1'b1, '{1, 0, 1, 1, 1, 0}}); // same block hits
      rows.push_back('{'{CMD_STORE, '1}, 1'b0, z});                     // all-ones address
      rows.push_back('{'{CMD_MODIFY, 64'h1234_5678_9ABC_DEF0}, 1'b0, z});
      rows.push_back('{'{CMD_MODIFY, 64'h1234_5678_9ABC_DEF0}, 1'b0, z});
      rows.push_back('{'{CMD_BAD, '1}, 1'b0, z});
      for (int i = 0; i < 10; i++)                                     // one set, past 8 ways
         rows.push_back('{'{2'(i % 3), 64'(i) << 12}, 1'b0, z});
      rows.push_back('{'{CMD_LOAD, 64'h0}, 1'b0, z});
      rows.push_back('{'{CMD_LOAD, 64'h8000_0000_0000_0000}, 1'b0, z});
      foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
      drain();

      // Sweep settings, extremes included; each phase gets its idling mode.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_csr(CSR_SET_BITS, 5'd0); write_csr(CSR_BLOCK_BITS, 5'd0);
                     write_csr(CSR_WAYS, 5'd1); end
            1: begin write_csr(CSR_SET_BITS, 5'd8); write_csr(CSR_BLOCK_BITS, 5'd16);
                     write_csr(CSR_WAYS, 5'd8); end
            2: begin write_csr(CSR_SET_BITS, 5'd15); write_csr(CSR_BLOCK_BITS, 5'd31);
                     write_csr(CSR_WAYS, 5'd0); end
            3: begin write_csr(CSR_SET_BITS, 5'd2); write_csr(CSR_BLOCK_BITS, 5'd3);
                     write_csr(CSR_WAYS, 5'd15); end
            default: begin
               write_csr(CSR_SET_BITS, 5'($urandom_range(9)));
               write_csr(CSR_BLOCK_BITS, 5'($urandom_range(17)));
               write_csr(CSR_WAYS, 5'($urandom_range(9)));
            end
         endcase
         idle_mode = idle_mode_type'(phase % 4);
         for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
         // Hold the receiver off while the sender keeps offering beats.
         if (phase == 5) hold_off = 200;
         for (int i = 0; i < 85; i++) begin
            r = random_item(pool);
            send_item(r, 1'b0, z);
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule
`default_nettype wire
